/* hdl/camera_ray_generator_macros.svh */
// assertion macros for the camera ray generator
// no dependencies; included by the modules that carry assertions
`ifndef CAMERA_RAY_GENERATOR_MACROS_SVH
`define CAMERA_RAY_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CRG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("camera ray generator assertion failed");
`define CRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("camera ray generator assertion failed");
`else
`define CRG_ASSERT_SAME(label, clk, rst, ante, cons)
`define CRG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/crg_pkg.sv */
// shared types, widths and helpers of the camera ray generator
// no dependencies
`default_nettype none
package crg_pkg;
   localparam int COMP_W    = 21;
   localparam int VEC_W     = 63;
   localparam int THR_W     = 15;
   localparam int FIELD_W   = 16;
   localparam int SCALED_W  = 30;
   localparam int TOP_BIT   = 29;
   localparam int SQ_W      = 60;
   localparam int SUMSQ_W   = 62;
   localparam int ROOT_W    = 31;
   localparam int REM_W     = 35;
   localparam int QUO_W     = 16;
   localparam int DIV_R_W   = 32;
   localparam int NUM_W     = 46;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE      = 2'd0,
      CSR_STEP_X    = 2'd1,
      CSR_STEP_Y    = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_W-1:0] px;
      logic [FIELD_W-1:0] py;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] dir_x;
      logic signed [FIELD_W-1:0] dir_y;
      logic signed [FIELD_W-1:0] dir_z;
   } rsp_word_type;

   // control bits that travel with each word
   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } crg_tag_type;

   typedef logic [SCALED_W-1:0] scaled_type;
   typedef logic [QUO_W-1:0]    quo_type;

   function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] vec,
                                                        input int unsigned k);
      return $signed(vec[k*COMP_W +: COMP_W]);
   endfunction
endpackage
`default_nettype wire

/* hdl/crg_dot.sv */
// direction sum stages: coordinate register, products, signed sums
// depends on crg_pkg
`default_nettype none
module crg_dot import crg_pkg::*; #(
   parameter int COORD_W = 16,
   parameter int MAG_W   = 38
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire req_word_type             in_word,
   input  wire logic [VEC_W-1:0]         base_vec,
   input  wire logic [VEC_W-1:0]         step_x_vec,
   input  wire logic [VEC_W-1:0]         step_y_vec,
   output crg_tag_type                   tag_out,
   output logic [2:0][MAG_W-1:0]         mag_out
);
   localparam int PROD_W = COORD_W + 1 + COMP_W;
   localparam int SUM_W  = MAG_W + 1;

   logic                       valid_a_ff, valid_b_ff;
   logic [COORD_W-1:0]         xa_ff, ya_ff;
   logic signed [PROD_W-1:0]   px_ff [3];
   logic signed [PROD_W-1:0]   py_ff [3];
   logic signed [PROD_W-1:0]   px_in [3];
   logic signed [PROD_W-1:0]   py_in [3];
   logic signed [SUM_W-1:0]    sum_c [3];
   crg_tag_type                tag_ff, tag_in;
   logic [2:0][MAG_W-1:0]      mag_ff, mag_in;

   // stage a: masked coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         tag_ff     <= '0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         tag_ff     <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff <= in_word.px[COORD_W-1:0];
      ya_ff <= in_word.py[COORD_W-1:0];
   end

   // stage b: step products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         px_in[k] = PROD_W'($signed({1'b0, xa_ff})) * PROD_W'(comp_of(step_x_vec, k));
         py_in[k] = PROD_W'($signed({1'b0, ya_ff})) * PROD_W'(comp_of(step_y_vec, k));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         px_ff[k] <= px_in[k];
         py_ff[k] <= py_in[k];
      end
   end

   // stage c: sums, sign and magnitude
   always_comb begin
      tag_in       = '0;
      tag_in.valid = valid_b_ff;
      for (int k = 0; k < 3; k++) begin
         sum_c[k] = (SUM_W'(comp_of(base_vec, k)) <<< 4) + SUM_W'(px_ff[k])
                    + SUM_W'(py_ff[k]);
         tag_in.neg[k] = sum_c[k][SUM_W-1];
         mag_in[k] = sum_c[k][SUM_W-1] ? MAG_W'(-sum_c[k]) : MAG_W'(sum_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
   end

   assign tag_out = tag_ff;
   assign mag_out = mag_ff;
endmodule
`default_nettype wire

/* hdl/crg_scale.sv */
// scaling stages: maximum, leading one, common shift, squares, sum of squares
// depends on crg_pkg
`default_nettype none
module crg_scale import crg_pkg::*; #(
   parameter int MAG_W = 38
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crg_tag_type           tag_in,
   input  wire logic [2:0][MAG_W-1:0] mag_in,
   output crg_tag_type                tag_out,
   output scaled_type [2:0]           scaled_out,
   output logic [SUMSQ_W-1:0]         sumsq_out
);
   localparam int P_W = $clog2(MAG_W);

   crg_tag_type           tag_d_ff, tag_e_ff, tag_f_ff, tag_g_ff, tag_h_ff, tag_d_in;
   logic [2:0][MAG_W-1:0] mag_d_ff, mag_e_ff;
   logic [MAG_W-1:0]      max_in, max_d_ff;
   logic [P_W-1:0]        p_in, p_e_ff;
   scaled_type [2:0]      scaled_in, scaled_f_ff, scaled_g_ff, scaled_h_ff;
   logic [SQ_W-1:0]       sq_g_ff [3];
   logic [SUMSQ_W-1:0]    sumsq_h_ff;

   always_comb begin
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];
      tag_d_in      = tag_in;
      tag_d_in.zero = (max_in == '0);
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (max_d_ff[i]) p_in = P_W'(i);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (p_e_ff > P_W'(TOP_BIT)) begin
            scaled_in[k] = SCALED_W'(mag_e_ff[k] >> (p_e_ff - P_W'(TOP_BIT)));
         end else begin
            scaled_in[k] = SCALED_W'((MAG_W + SCALED_W)'(mag_e_ff[k])
                                     << (P_W'(TOP_BIT) - p_e_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff <= '0;
         tag_e_ff <= '0;
         tag_f_ff <= '0;
         tag_g_ff <= '0;
         tag_h_ff <= '0;
      end else begin
         tag_d_ff <= tag_d_in;
         tag_e_ff <= tag_d_ff;
         tag_f_ff <= tag_e_ff;
         tag_g_ff <= tag_f_ff;
         tag_h_ff <= tag_g_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_d_ff    <= mag_in;
      max_d_ff    <= max_in;
      mag_e_ff    <= mag_d_ff;
      p_e_ff      <= p_in;
      scaled_f_ff <= scaled_in;
      scaled_g_ff <= scaled_f_ff;
      scaled_h_ff <= scaled_g_ff;
      for (int k = 0; k < 3; k++) begin
         sq_g_ff[k] <= SQ_W'(scaled_f_ff[k]) * SQ_W'(scaled_f_ff[k]);
      end
      sumsq_h_ff <= SUMSQ_W'(sq_g_ff[0]) + SUMSQ_W'(sq_g_ff[1]) + SUMSQ_W'(sq_g_ff[2]);
   end

   assign tag_out    = tag_h_ff;
   assign scaled_out = scaled_h_ff;
   assign sumsq_out  = sumsq_h_ff;
endmodule
`default_nettype wire

/* hdl/crg_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on crg_pkg
`default_nettype none
module crg_sqrt import crg_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crg_tag_type          tag_in,
   input  wire scaled_type [2:0]     scaled_in,
   input  wire logic [SUMSQ_W-1:0]   sumsq_in,
   output crg_tag_type               tag_out,
   output scaled_type [2:0]          scaled_out,
   output logic [ROOT_W-1:0]         root_out
);
   logic [REM_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   logic [SUMSQ_W-1:0] rad_ff  [ROOT_W];
   crg_tag_type        tag_ff  [ROOT_W];
   scaled_type [2:0]   mag_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [REM_W-1:0]   rem_prev, rem_sh, trial;
      logic [ROOT_W-1:0]  root_prev;
      logic [SUMSQ_W-1:0] rad_prev;
      crg_tag_type        tag_prev;
      scaled_type [2:0]   mag_prev;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = sumsq_in;
         assign tag_prev  = tag_in;
         assign mag_prev  = scaled_in;
      end else begin : g_rest
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign tag_prev  = tag_ff[i-1];
         assign mag_prev  = mag_ff[i-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[SUMSQ_W-1 -: 2]};
      assign trial  = REM_W'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (rem_sh >= trial) begin
            rem_ff[i]  <= rem_sh - trial;
            root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem_sh;
            root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
         end
         rad_ff[i] <= rad_prev << 2;
         mag_ff[i] <= mag_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else begin
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign tag_out    = tag_ff[ROOT_W-1];
   assign scaled_out = mag_ff[ROOT_W-1];
   assign root_out   = root_ff[ROOT_W-1];
endmodule
`default_nettype wire

/* hdl/crg_div.sv */
// pipelined rounding divide of each scaled component by the norm, three lanes
// depends on crg_pkg
`default_nettype none
module crg_div import crg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire crg_tag_type       tag_in,
   input  wire scaled_type [2:0]  scaled_in,
   input  wire logic [ROOT_W-1:0] norm_in,
   output crg_tag_type            tag_out,
   output quo_type [2:0]          quo_out
);
   logic [NUM_W-1:0]           num_in [3];
   logic [2:0][DIV_R_W-1:0]    r0_ff;
   logic [2:0][QUO_W-1:0]      low0_ff;
   logic [ROOT_W-1:0]          n0_ff;
   crg_tag_type                tag0_ff;

   logic [2:0][DIV_R_W-1:0]    r_ff   [QUO_W];
   logic [2:0][QUO_W-1:0]      low_ff [QUO_W];
   quo_type [2:0]              q_ff   [QUO_W];
   logic [ROOT_W-1:0]          n_ff   [QUO_W];
   crg_tag_type                tag_ff [QUO_W];

   // numerator a*32768 + n/2; its top part is already below n
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = (NUM_W'(scaled_in[k]) << 15) + NUM_W'(norm_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         r0_ff[k]   <= DIV_R_W'(num_in[k][NUM_W-1:QUO_W]);
         low0_ff[k] <= num_in[k][QUO_W-1:0];
      end
      n0_ff <= norm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else begin
         tag0_ff <= tag_in;
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [2:0][DIV_R_W-1:0] r_prev;
      logic [2:0][QUO_W-1:0]   low_prev;
      quo_type [2:0]           q_prev;
      logic [ROOT_W-1:0]       n_prev;
      crg_tag_type             tag_prev;
      logic [DIV_R_W-1:0]      r_sh [3];

      if (i == 0) begin : g_first
         assign r_prev   = r0_ff;
         assign low_prev = low0_ff;
         assign q_prev   = '0;
         assign n_prev   = n0_ff;
         assign tag_prev = tag0_ff;
      end else begin : g_rest
         assign r_prev   = r_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign n_prev   = n_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            r_sh[k] = {r_prev[k][DIV_R_W-2:0], low_prev[k][QUO_W-1]};
         end
      end

      always_ff @(posedge clock) begin
         for (int k = 0; k < 3; k++) begin
            if (r_sh[k] >= DIV_R_W'(n_prev)) begin
               r_ff[i][k] <= r_sh[k] - DIV_R_W'(n_prev);
               q_ff[i][k] <= {q_prev[k][QUO_W-2:0], 1'b1};
            end else begin
               r_ff[i][k] <= r_sh[k];
               q_ff[i][k] <= {q_prev[k][QUO_W-2:0], 1'b0};
            end
            low_ff[i][k] <= low_prev[k] << 1;
         end
         n_ff[i] <= n_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else begin
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign tag_out = tag_ff[QUO_W-1];
   assign quo_out = q_ff[QUO_W-1];
endmodule
`default_nettype wire

/* hdl/camera_ray_generator.sv */
// top level of the camera ray generator: registers, pipeline, output stage
// depends on crg_pkg, crg_dot, crg_scale, crg_sqrt, crg_div and the macro header
// result path: start passes the dot, scale, square root and divide stages, then the output register
// throughput: one sample per clock; busy stays low, a word may enter every cycle
// the length is set by the 31-stage square root and the 16-stage divider lanes
// reset is synchronous: clears all valid bits, vector registers to 0, threshold to 1
// the receiver cannot stall, so nothing in the pipeline ever holds
`default_nettype none
`include "camera_ray_generator_macros.svh"
module camera_ray_generator import crg_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_word_type         req_data,
   output logic                      rsp_valid,
   output rsp_word_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [VEC_W-1:0]     csr_wdata
);
   // coordinate bits that count: the input field is never wider than its port
   localparam int COORD_W = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int MAG_W   = COORD_W + 22;

   // configuration registers
   logic [VEC_W-1:0] base_ff, step_x_ff, step_y_ff;
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         thr_ff    <= THR_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE:      base_ff   <= csr_wdata;
            CSR_STEP_X:    step_x_ff <= csr_wdata;
            CSR_STEP_Y:    step_y_ff <= csr_wdata;
            CSR_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline never stalls
   assign busy = 1'b0;

   crg_tag_type            dot_tag, scl_tag, sqr_tag, fin_tag;
   logic [2:0][MAG_W-1:0]  dot_mag;
   scaled_type [2:0]       scl_mag, sqr_mag;
   logic [SUMSQ_W-1:0]     scl_sumsq;
   logic [ROOT_W-1:0]      sqr_root;
   quo_type [2:0]          fin_quo;

   // products and signed sums per component
   crg_dot #(
      .COORD_W (COORD_W),
      .MAG_W   (MAG_W)
   ) u_dot (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_word    (req_data),
      .base_vec   (base_ff),
      .step_x_vec (step_x_ff),
      .step_y_vec (step_y_ff),
      .tag_out    (dot_tag),
      .mag_out    (dot_mag)
   );

   // common shift so the largest magnitude lands in [2^29, 2^30), then squares
   crg_scale #(
      .MAG_W (MAG_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .tag_in     (dot_tag),
      .mag_in     (dot_mag),
      .tag_out    (scl_tag),
      .scaled_out (scl_mag),
      .sumsq_out  (scl_sumsq)
   );

   // vector norm
   crg_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .tag_in     (scl_tag),
      .scaled_in  (scl_mag),
      .sumsq_in   (scl_sumsq),
      .tag_out    (sqr_tag),
      .scaled_out (sqr_mag),
      .root_out   (sqr_root)
   );

   // component / norm in Q1.15, rounded half up
   crg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (sqr_tag),
      .scaled_in (sqr_mag),
      .norm_in   (sqr_root),
      .tag_out   (fin_tag),
      .quo_out   (fin_quo)
   );

   // output stage: saturate, clear below threshold, apply sign
   logic [FIELD_W-1:0] dir_in [3];
   logic [FIELD_W-1:0] lim_c  [3];
   logic [FIELD_W-1:0] sat_c  [3];
   rsp_word_type       rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // a negative result may reach -32768, a positive one only 32767
         lim_c[k] = fin_tag.neg[k] ? 16'h8000 : 16'h7fff;
         sat_c[k] = (fin_quo[k] > lim_c[k]) ? lim_c[k] : fin_quo[k];
         if (sat_c[k] < {1'b0, thr_ff}) sat_c[k] = '0;
         dir_in[k] = fin_tag.neg[k] ? (FIELD_W'(0) - sat_c[k]) : sat_c[k];
         // all-zero sum vector gives a zero direction
         if (fin_tag.zero) dir_in[k] = '0;
      end
      rsp_data_in.dir_x = $signed(dir_in[0]);
      rsp_data_in.dir_y = $signed(dir_in[1]);
      rsp_data_in.dir_z = $signed(dir_in[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // magnitude of the x output word, for the threshold check
   logic [FIELD_W-1:0] abs_x;
   assign abs_x = rsp_data.dir_x[FIELD_W-1] ? (FIELD_W'(0) - FIELD_W'(rsp_data.dir_x))
                                            : FIELD_W'(rsp_data.dir_x);

   `CRG_ASSERT_NEXT(a_zero_vec, clock, reset, fin_tag.valid && fin_tag.zero, rsp_valid && rsp_data == '0)
   `CRG_ASSERT_SAME(a_thr_x, clock, reset, rsp_valid && rsp_data.dir_x != 16'sd0, abs_x >= {1'b0, thr_ff})
   `CRG_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)
endmodule
`default_nettype wire

/* sim/tb_camera_ray_generator.sv */
// testbench for camera_ray_generator: random and directed sample positions
// predicts each unit ray direction in place and compares it with the rsp_ word
// depends on crg_pkg and the camera_ray_generator rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_camera_ray_generator;
   import crg_pkg::*;

   localparam int COORD_BITS = 16;
   localparam int LATENCY    = 57;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_word_type         req_data = '0;
   logic                 rsp_valid;
   rsp_word_type         rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE;
   logic [VEC_W-1:0]     csr_wdata = '0;

   camera_ray_generator #(.COORD_BITS(COORD_BITS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor copy of the registers
   logic [VEC_W-1:0] base_reg, stepx_reg, stepy_reg;
   logic [THR_W-1:0] thr_reg;

   req_word_type sample_queue[$];
   rsp_word_type direction_queue[$];
   int unsigned  error_count = 0;
   int           send_idle_pct = 0;

   function automatic longint signed vec_comp(input logic [VEC_W-1:0] vec, input int k);
      logic signed [COMP_W-1:0] c;
      c = vec[k*COMP_W +: COMP_W];
      return longint'(c);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // unit direction for one sample position
   function automatic rsp_word_type ray_direction(input req_word_type w);
      longint signed   x, y, v;
      longint unsigned mag[3], m, s, n, q, lim, t;
      bit              neg[3];
      int              p;
      logic [15:0]     out[3];
      rsp_word_type    r;
      x = longint'(w.px[COORD_BITS-1:0]);
      y = longint'(w.py[COORD_BITS-1:0]);
      m = 0;
      for (int k = 0; k < 3; k++) begin
         v = vec_comp(base_reg, k) * 16 + x * vec_comp(stepx_reg, k)
             + y * vec_comp(stepy_reg, k);
         neg[k] = v < 0;
         mag[k] = neg[k] ? longint'(-v) : longint'(v);
         if (mag[k] > m) m = mag[k];
      end
      if (m == 0) return '0;
      p = 0;
      t = m;
      while (t > 1) begin
         t >>= 1;
         p++;
      end
      s = 0;
      for (int k = 0; k < 3; k++) begin
         if (p > TOP_BIT) mag[k] >>= (p - TOP_BIT);
         else mag[k] <<= (TOP_BIT - p);
         s += mag[k] * mag[k];
      end
      n = int_sqrt(s);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 32768 + (n >> 1)) / n;
         lim = neg[k] ? 32768 : 32767;
         if (q > lim) q = lim;
         if (q < thr_reg) q = 0;
         out[k] = neg[k] ? 16'(-q) : 16'(q);
      end
      r.dir_x = out[0];
      r.dir_y = out[1];
      r.dir_z = out[2];
      return r;
   endfunction

   // driver: one word per accepted cycle, random gaps
   always @(negedge clock) begin
      if (!reset && start && !busy) begin
         direction_queue.push_back(ray_direction(req_data));
         void'(sample_queue.pop_front());
      end
      if (!reset && sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         start <= 1'b1;
         req_data <= sample_queue[0];
      end else begin
         start <= 1'b0;
         req_data <= $urandom;
      end
   end

   // monitor: compare each strobed word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid) begin
         if (direction_queue.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            exp_w = direction_queue.pop_front();
            if (exp_w.dir_x !== rsp_data.dir_x || exp_w.dir_y !== rsp_data.dir_y ||
                exp_w.dir_z !== rsp_data.dir_z) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %h actual %h", exp_w, rsp_data);
            end
         end
      end
   end

   // wait until every queued sample is taken and every word has come back
   task automatic drain();
      while (sample_queue.size() > 0 || start) @(posedge clock);
      while (direction_queue.size() > 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [VEC_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BASE:      base_reg = val;
         CSR_STEP_X:    stepx_reg = val;
         CSR_STEP_Y:    stepy_reg = val;
         CSR_THRESHOLD: thr_reg = val[THR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [VEC_W-1:0] rand_vec();
      return VEC_W'({$urandom, $urandom});
   endfunction

   // vector packed from three signed components, the first in the low bits
   function automatic logic [VEC_W-1:0] pack_vec(input int a, input int b, input int c);
      logic [COMP_W-1:0] xa, xb, xc;
      xa = COMP_W'(a);
      xb = COMP_W'(b);
      xc = COMP_W'(c);
      return {xc, xb, xa};
   endfunction

   task automatic add_samples(input int count, input int max_coord);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) w = $urandom;
         else begin
            w.px = FIELD_W'($urandom_range(max_coord));
            w.py = FIELD_W'($urandom_range(max_coord));
         end
         sample_queue.push_back(w);
      end
   endtask

   initial begin
      base_reg = '0;
      stepx_reg = '0;
      stepy_reg = '0;
      thr_reg = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero vector at reset values, then coordinate extremes
      sample_queue.push_back('{px: 16'h0000, py: 16'h0000});
      sample_queue.push_back('{px: 16'hffff, py: 16'hffff});
      drain();
      write_reg(CSR_BASE, pack_vec(-1000, 2000, 16384));
      write_reg(CSR_STEP_X, pack_vec(3, 0, 0));
      write_reg(CSR_STEP_Y, pack_vec(0, -3, 0));
      write_reg(CSR_THRESHOLD, '0);
      sample_queue.push_back('{px: 16'h0000, py: 16'h0000});
      sample_queue.push_back('{px: 16'hffff, py: 16'h0000});
      sample_queue.push_back('{px: 16'h0000, py: 16'hffff});
      sample_queue.push_back('{px: 16'h5555, py: 16'haaaa});
      drain();
      // extreme components: most negative and most positive
      write_reg(CSR_BASE, pack_vec(-1048576, 1048575, 0));
      write_reg(CSR_STEP_X, pack_vec(-1048576, -1048576, -1048576));
      write_reg(CSR_STEP_Y, pack_vec(1048575, 1048575, 1048575));
      sample_queue.push_back('{px: 16'h0000, py: 16'h0000});
      sample_queue.push_back('{px: 16'hffff, py: 16'h0000});
      sample_queue.push_back('{px: 16'h0000, py: 16'hffff});
      sample_queue.push_back('{px: 16'hffff, py: 16'hffff});
      drain();
      // threshold clearing: large threshold wipes small components, full mask too
      write_reg(CSR_BASE, pack_vec(100, -50, 16000));
      write_reg(CSR_STEP_X, '0);
      write_reg(CSR_STEP_Y, '0);
      write_reg(CSR_THRESHOLD, VEC_W'(2000));
      sample_queue.push_back('{px: 16'h1234, py: 16'h4321});
      drain();
      write_reg(CSR_THRESHOLD, VEC_W'(15'h7fff));
      sample_queue.push_back('{px: 16'h0001, py: 16'h0001});
      drain();
      write_reg(CSR_BASE, pack_vec(0, 0, -16384));
      sample_queue.push_back('{px: 16'h0001, py: 16'h0001});
      drain();

      // random phases with differing sender idle rates and settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: send_idle_pct = 0;
            1: send_idle_pct = 60;
            2: send_idle_pct = 28;
            default: send_idle_pct = 0;
         endcase
         if (phase % 2 == 0) begin
            write_reg(CSR_BASE, rand_vec());
            write_reg(CSR_STEP_X, rand_vec());
            write_reg(CSR_STEP_Y, rand_vec());
         end else begin
            write_reg(CSR_BASE, pack_vec($urandom_range(40000) - 20000,
                                         $urandom_range(40000) - 20000, 16384));
            write_reg(CSR_STEP_X, pack_vec($urandom_range(8) + 1, 0, $urandom_range(4)));
            write_reg(CSR_STEP_Y, pack_vec(0, -($urandom_range(8) + 1), 0));
         end
         write_reg(CSR_THRESHOLD,
                   VEC_W'(phase == 3 ? 0 : $urandom_range(phase < 4 ? 4 : 1024)));
         add_samples(60, 16'hffff);
         drain();
         // hold-off: pause sending until every expectation has arrived
         add_samples(60, phase % 2 ? 16'h3fff : 16'hffff);
         drain();
      end
      if (error_count == 0) $display("tb_camera_ray_generator passed");
      else $display("tb_camera_ray_generator failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_camera_ray_generator failed");
      $finish;
   end
endmodule
`default_nettype wire
